// ===== hw/rtl/gpc_pkg.sv =====
// Shared types and constants for the grid path counter.
// Holds the modulus, field widths, register selects and the token that
// travels down the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpc_pkg;

    localparam int COUNT_W   = 30;
    localparam int DIM_W     = 9;
    localparam int COL_IDX_W = 12;

    localparam logic [COUNT_W-1:0] PATH_MOD = 30'd1000000007;

    // Register select, taken from the word address of the configuration port.
    typedef enum logic {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } cfg_sel_t;

    // One grid cell on its way down the chain. The value is filled in by the
    // cell whose index matches col.
    typedef struct packed {
        logic                 valid;
        logic                 blocked;
        logic                 row_nz;
        logic                 adj;
        logic                 final_cell;
        logic [COL_IDX_W-1:0] col;
        logic [COUNT_W-1:0]   val;
    } gpc_token_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gpc_if.sv =====
// Valid/ready stream interfaces for the grid words and the result words.
// Depends on gpc_pkg for the count width.
`timescale 1ns / 1ps
`default_nettype none

interface gpc_grid_if;
    logic valid;
    logic ready;
    logic blocked;

    modport source (output valid, output blocked, input ready);
    modport sink (input valid, input blocked, output ready);
endinterface

interface gpc_result_if;
    logic                         valid;
    logic                         ready;
    logic [gpc_pkg::COUNT_W-1:0]  path_count;

    modport source (output valid, output path_count, input ready);
    modport sink (input valid, input path_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gpc_cell.sv =====
// One cell of the chain: holds one column of the line store and one token
// stage. Computes a grid cell's count when the token's column matches.
// Depends on gpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpc_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              advance,
    input  wire gpc_pkg::gpc_token_t         tok_in,
    input  wire [gpc_pkg::COUNT_W-1:0]       left_nb,
    input  wire [gpc_pkg::COUNT_W-1:0]       tail_left,
    output gpc_pkg::gpc_token_t              tok_out,
    output logic [gpc_pkg::COUNT_W-1:0]      store_out
);
    import gpc_pkg::*;

    gpc_token_t          tok_reg;
    gpc_token_t          tok_next;
    logic [COUNT_W-1:0]  store_reg;
    logic [COUNT_W-1:0]  store_next;
    logic                hit;
    logic                col_zero;
    logic [COUNT_W-1:0]  up_val;
    logic [COUNT_W-1:0]  left_val;
    logic [COUNT_W:0]    sum;
    logic [COUNT_W-1:0]  cell_val;

    assign hit      = tok_in.valid && (tok_in.col == COL_IDX_W'(CELL_IDX));
    assign col_zero = (tok_in.col == '0);

    // The neighbor's store holds the previous word's count when that word sat
    // one column to the left; otherwise the chain has drained and the tail
    // copy is the previous count.
    assign up_val   = tok_in.row_nz ? store_reg : '0;
    assign left_val = col_zero ? '0 : (tok_in.adj ? left_nb : tail_left);
    assign sum      = {1'b0, up_val} + {1'b0, left_val};

    always_comb
    begin
        priority if (tok_in.blocked)
        begin
            cell_val = '0;
        end
        else if (!tok_in.row_nz && col_zero)
        begin
            cell_val = COUNT_W'(1);
        end
        else if (sum >= {1'b0, PATH_MOD})
        begin
            cell_val = COUNT_W'(sum - {1'b0, PATH_MOD});
        end
        else
        begin
            cell_val = sum[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        tok_next   = tok_in;
        store_next = store_reg;
        if (hit)
        begin
            tok_next.val = cell_val;
            store_next   = cell_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            store_reg <= store_next;
        end
    end

    assign tok_out   = tok_reg;
    assign store_out = store_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_path_count_with_obstacles.sv =====
// Top level of the grid path counter: position tracking, configuration
// registers, the chain of gpc_cell stages and the result register.
// Depends on gpc_pkg, gpc_grid_if, gpc_result_if and gpc_cell.
//
//   Channel   Kind            Word / fields
//   grid      stream in       blocked (1 bit), one grid cell per word
//   result    stream out      path_count (30 bits), one word per finished grid
//   APB       config r/w      0x0 row_count, 0x4 col_count (9 bits each)
//
// One grid word is accepted per cycle unless the chain stalls. Each word walks
// the chain of MAX_COLS cells, one cell per advancing cycle, and is computed in
// the cell of its column. The last count of a grid goes to the result register.
// Reset clears the positions and the left count and sets both registers to 1.
// The chain and the input stall only while a finished count waits at the end
// of the chain and the result register is still held by the sink.
// The user must write the registers only with the chain empty; the block
// itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module grid_path_count_with_obstacles #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  wire                 clk,
    input  wire                 rst_n,
    gpc_grid_if.sink            grid,
    gpc_result_if.source        result,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gpc_pkg::*;

    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLIM_W = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
    localparam int RLIM_W = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;

    logic [DIM_W-1:0]    row_count_reg;
    logic [DIM_W-1:0]    row_count_next;
    logic [DIM_W-1:0]    col_count_reg;
    logic [DIM_W-1:0]    col_count_next;
    logic [CW-1:0]       col_pos_reg;
    logic [CW-1:0]       col_pos_next;
    logic [RW-1:0]       row_pos_reg;
    logic [RW-1:0]       row_pos_next;
    logic [CW-1:0]       prev_col_reg;
    logic [CW-1:0]       prev_col_next;
    logic [COUNT_W-1:0]  last_val_reg;
    logic [COUNT_W-1:0]  last_val_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COUNT_W-1:0]  path_count_reg;
    logic [COUNT_W-1:0]  path_count_next;

    logic                cfg_write;
    cfg_sel_t            cfg_sel;
    logic [RLIM_W-1:0]   rows_ext;
    logic [RLIM_W-1:0]   rows_eff;
    logic [CLIM_W-1:0]   cols_ext;
    logic [CLIM_W-1:0]   cols_eff;
    logic [CLIM_W-1:0]   col_pos_ext;
    logic [CLIM_W-1:0]   col_ext;
    logic [CW-1:0]       col_cur;
    logic                col_last;
    logic                row_last;
    logic                adv;
    logic                accept;
    logic                load_out;

    gpc_token_t          head_tok;
    gpc_token_t          tail_tok;
    gpc_token_t          tok_w [MAX_COLS+1];
    logic [COUNT_W-1:0]  store_w [MAX_COLS];

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_sel_t'(paddr[2]);

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_write)
        begin
            unique case (cfg_sel)
                CFG_ROW_COUNT: row_count_next = pwdata[DIM_W-1:0];
                CFG_COL_COUNT: col_count_next = pwdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            CFG_ROW_COUNT: prdata = {{(32-DIM_W){1'b0}}, row_count_reg};
            CFG_COL_COUNT: prdata = {{(32-DIM_W){1'b0}}, col_count_reg};
            default:       prdata = '0;
        endcase
    end

    // Effective grid size: zero acts as one, anything above the maximum
    // acts as the maximum.
    assign rows_ext = RLIM_W'(row_count_reg);
    assign cols_ext = CLIM_W'(col_count_reg);

    always_comb
    begin
        priority if (row_count_reg == '0)
        begin
            rows_eff = RLIM_W'(1);
        end
        else if (rows_ext > RLIM_W'(MAX_ROWS))
        begin
            rows_eff = RLIM_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_ext;
        end
    end

    always_comb
    begin
        priority if (col_count_reg == '0)
        begin
            cols_eff = CLIM_W'(1);
        end
        else if (cols_ext > CLIM_W'(MAX_COLS))
        begin
            cols_eff = CLIM_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = cols_ext;
        end
    end

    // A position left beyond a shrunken grid is taken as its last column.
    assign col_pos_ext = CLIM_W'(col_pos_reg);
    assign col_ext     = (col_pos_ext >= cols_eff) ? (cols_eff - CLIM_W'(1)) : col_pos_ext;
    assign col_cur     = col_ext[CW-1:0];
    assign col_last    = (col_ext + CLIM_W'(1)) >= cols_eff;
    assign row_last    = (RLIM_W'(row_pos_reg) + RLIM_W'(1)) >= rows_eff;

    // The chain holds only while a finished count cannot leave its tail.
    assign tail_tok = tok_w[MAX_COLS];
    assign adv      = !(tail_tok.valid && tail_tok.final_cell && out_valid_reg && !result.ready);
    assign accept   = grid.valid && adv;
    assign load_out = adv && tail_tok.valid && tail_tok.final_cell;

    assign grid.ready = adv;

    always_comb
    begin
        head_tok            = '0;
        head_tok.valid      = accept;
        head_tok.blocked    = grid.blocked;
        head_tok.row_nz     = (row_pos_reg != '0);
        head_tok.adj        = (col_ext == (CLIM_W'(prev_col_reg) + CLIM_W'(1)));
        head_tok.final_cell = col_last && row_last;
        head_tok.col        = COL_IDX_W'(col_cur);
    end

    always_comb
    begin
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        prev_col_next = prev_col_reg;
        if (accept)
        begin
            prev_col_next = col_cur;
            if (col_last)
            begin
                col_pos_next = '0;
                row_pos_next = row_last ? '0 : (row_pos_reg + RW'(1));
            end
            else
            begin
                col_pos_next = CW'(col_ext + CLIM_W'(1));
            end
        end
    end

    // Words leave the tail in arrival order, so once the chain is empty this
    // register holds the count of the last word, cleared after a grid ends.
    always_comb
    begin
        last_val_next = last_val_reg;
        if (adv && tail_tok.valid)
        begin
            last_val_next = tail_tok.final_cell ? '0 : tail_tok.val;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        path_count_next = path_count_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            path_count_next = tail_tok.val;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.path_count = path_count_reg;

    assign tok_w[0] = head_tok;

    for (genvar k = 0; k < MAX_COLS; k++)
    begin : g_cell
        logic [COUNT_W-1:0] left_nb;

        if (k == 0)
        begin : g_first
            assign left_nb = '0;
        end
        else
        begin : g_rest
            assign left_nb = store_w[k-1];
        end

        gpc_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (adv),
            .tok_in    (tok_w[k]),
            .left_nb   (left_nb),
            .tail_left (last_val_reg),
            .tok_out   (tok_w[k+1]),
            .store_out (store_w[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= DIM_W'(1);
            col_count_reg <= DIM_W'(1);
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            prev_col_reg  <= '0;
            last_val_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            prev_col_reg  <= prev_col_next;
            last_val_reg  <= last_val_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        path_count_reg <= path_count_next;
    end

    // A stall is only ever caused by a finished count blocked at the tail.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> (tail_tok.valid && tail_tok.final_cell && out_valid_reg))
        else $error("chain stalled without a blocked result at its tail");

    // An accepted word is in the first cell on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (grid.valid && grid.ready) |=> tok_w[1].valid)
        else $error("accepted word missing from the first cell");

    // A finished count leaving the chain is offered on the result channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (result.valid && (result.path_count == $past(tail_tok.val))))
        else $error("finished count not presented as a result word");

    // Without a finished count at the tail the chain never holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(tail_tok.valid && tail_tok.final_cell) |-> grid.ready)
        else $error("input refused while the chain tail is free");

endmodule

`default_nettype wire

// ===== tb/sv/grid_path_count_checker.sv =====
// Scoreboard for the grid path counter: follows register writes and grid words,
// predicts each finished grid's path count and compares it with the result word.
// Depends on gpc_pkg and the gpc_grid_if / gpc_result_if interfaces.
`timescale 1ns / 1ps

module grid_path_count_checker #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    gpc_grid_if         grid,
    gpc_result_if       result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          counts_waiting,
    output logic        sweep_at_origin,
    output int          cols_written
);
    import gpc_pkg::*;

    logic [DIM_W-1:0]   row_count_q;
    logic [DIM_W-1:0]   col_count_q;
    logic [COUNT_W-1:0] line_store [MAX_COLS];
    logic [COUNT_W-1:0] left_count;
    int                 row_pos;
    int                 col_pos;
    logic [COUNT_W-1:0] pending_counts [$];
    logic [COUNT_W-1:0] oldest_count;
    logic [DIM_W-1:0]   reg_value;
    string              reg_name;

    assign sweep_at_origin = (row_pos == 0) && (col_pos == 0);

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic int dim_in_use(input logic [DIM_W-1:0] value, input int limit);
        if (value == '0)
            return 1;
        if (int'(value) > limit)
            return limit;
        return int'(value);
    endfunction

    task automatic sweep_cell(input logic blk);
        int                 rows_in_use;
        int                 cols_in_use;
        int                 c;
        logic [COUNT_W-1:0] above;
        logic [COUNT_W-1:0] beside;
        logic [COUNT_W:0]   sum;
        logic [COUNT_W-1:0] count;
        rows_in_use = dim_in_use(row_count_q, MAX_ROWS);
        cols_in_use = dim_in_use(col_count_q, MAX_COLS);
        // A column position left beyond a shrunken grid is taken as its last column.
        c = (col_pos >= cols_in_use) ? cols_in_use - 1 : col_pos;
        above  = (row_pos > 0) ? line_store[c] : '0;
        beside = (c > 0) ? left_count : '0;
        sum = above + beside;
        if (sum >= PATH_MOD)
            sum = sum - PATH_MOD;
        if (blk)
            count = '0;
        else if (row_pos == 0 && c == 0)
            count = 1;
        else
            count = sum[COUNT_W-1:0];
        line_store[c] = count;
        left_count = count;
        if (c + 1 > cols_written)
            cols_written = c + 1;
        if (c + 1 >= cols_in_use)
        begin
            col_pos = 0;
            if (row_pos + 1 >= rows_in_use)
            begin
                row_pos = 0;
                left_count = '0;
                pending_counts.push_back(count);
            end
            else
            begin
                row_pos++;
            end
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_q = 1;
            col_count_q = 1;
            left_count = '0;
            row_pos = 0;
            col_pos = 0;
            pending_counts.delete();
            fail_count = 0;
            cols_written = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (cfg_sel_t'(paddr[2]) == CFG_ROW_COUNT)
                        row_count_q = pwdata[DIM_W-1:0];
                    else
                        col_count_q = pwdata[DIM_W-1:0];
                end
                else
                begin
                    if (cfg_sel_t'(paddr[2]) == CFG_ROW_COUNT)
                    begin
                        reg_name = "row_count";
                        reg_value = row_count_q;
                    end
                    else
                    begin
                        reg_name = "col_count";
                        reg_value = col_count_q;
                    end
                    if (prdata[DIM_W-1:0] !== reg_value)
                    begin
                        $error("%s: expected %0d, actual %0d", reg_name, reg_value,
                               prdata[DIM_W-1:0]);
                        fail_count++;
                    end
                end
            end
            if (result.valid && result.ready)
            begin
                if (pending_counts.size() == 0)
                begin
                    $error("path_count: expected no word, actual %0d", result.path_count);
                    fail_count++;
                end
                else
                begin
                    oldest_count = pending_counts.pop_front();
                    if (result.path_count !== oldest_count)
                    begin
                        $error("path_count: expected %0d, actual %0d", oldest_count,
                               result.path_count);
                        fail_count++;
                    end
                end
            end
            if (grid.valid && grid.ready)
                sweep_cell(grid.blocked);
        end
        counts_waiting = pending_counts.size();
    end

endmodule

// ===== tb/sv/grid_path_count_with_obstacles_tb.sv =====
// Testbench top for the grid path counter: clock, reset, grid word stimulus,
// register writes and reads, result back-pressure and the verdict.
// Depends on gpc_pkg, the stream interfaces, the block and grid_path_count_checker.
`timescale 1ns / 1ps

module grid_path_count_with_obstacles_tb;
    import gpc_pkg::*;

    localparam int MAX_COLS     = 256;
    localparam int MAX_ROWS     = 256;
    localparam int CELL_TARGET  = 1700;
    localparam int DRAIN_CYCLES = MAX_COLS + 8;
    localparam int STALL_LIMIT  = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          counts_waiting;
    int          cols_written;
    logic        sweep_at_origin;

    logic        cell_taken = 1'b0;
    logic        count_taken = 1'b0;
    logic        reg_taken = 1'b0;
    logic        steady = 1'b0;
    int          cells_sent = 0;
    int          idle_cycles = 0;

    gpc_grid_if   grid_ch ();
    gpc_result_if result_ch ();

    grid_path_count_with_obstacles #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .grid    (grid_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    grid_path_count_checker #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .grid            (grid_ch),
        .result          (result_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .counts_waiting  (counts_waiting),
        .sweep_at_origin (sweep_at_origin),
        .cols_written    (cols_written)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Handshake flags, read by the stimulus at the following falling edge.
    always @(posedge clk)
    begin
        cell_taken  <= (grid_ch.valid && grid_ch.ready) === 1'b1;
        count_taken <= (result_ch.valid && result_ch.ready) === 1'b1;
        reg_taken   <= (psel && penable && pready) === 1'b1;
    end

    always @(posedge clk)
    begin
        if (cell_taken || count_taken || reg_taken)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_cell(input logic blk);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            grid_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        grid_ch.valid   <= 1'b1;
        grid_ch.blocked <= blk;
        do @(negedge clk); while (!cell_taken);
        cells_sent++;
    endtask

    // Bit i of the pattern is the i-th cell in row-major order.
    task automatic send_cells(input logic [15:0] pattern, input int n);
        for (int i = 0; i < n; i++)
            send_cell(pattern[i]);
    endtask

    // Sends cells until the sweep is back at the top-left corner.
    task automatic finish_grid(input int blocked_pct);
        do send_cell($urandom_range(0, 99) < blocked_pct); while (!sweep_at_origin);
    endtask

    // Stops the grid stream until every count has come out and the chain is empty.
    task automatic wait_idle();
        grid_ch.valid <= 1'b0;
        do @(negedge clk); while (counts_waiting != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_transfer(input logic is_write, input cfg_sel_t sel,
                                input logic [DIM_W-1:0] value);
        logic [31:0] noise;
        noise = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {sel, 2'b00};
        pwdata  <= {noise[31:DIM_W], value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
        wait_idle();
        if ($urandom_range(0, 1) == 1)
        begin
            apb_transfer(1'b1, CFG_ROW_COUNT, rows);
            apb_transfer(1'b1, CFG_COL_COUNT, cols);
        end
        else
        begin
            apb_transfer(1'b1, CFG_COL_COUNT, cols);
            apb_transfer(1'b1, CFG_ROW_COUNT, rows);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            apb_transfer(1'b0, CFG_ROW_COUNT, '0);
            apb_transfer(1'b0, CFG_COL_COUNT, '0);
        end
    endtask

    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                // Hold off only once a word is offered, so the stall lands on it.
                result_ch.ready <= 1'b0;
                while (result_ch.valid !== 1'b1)
                    @(negedge clk);
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(negedge clk); while (!count_taken);
        end
    end

    initial
    begin
        int rows;
        int cols;
        int pct;
        int grids;
        int pick;
        int phase;
        int random_start;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        grid_ch.valid = 1'b0;
        grid_ch.blocked = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset leaves a one-cell grid: open gives one path, blocked gives none.
        send_cells(16'b10, 2);
        set_grid(2, 2);
        send_cells(16'b0000, 4);
        send_cells(16'b0001, 4);
        send_cells(16'b1000, 4);
        send_cells(16'b0110, 4);
        set_grid(1, 3);
        send_cells(16'b010, 3);
        // Zero registers act as a single cell.
        set_grid(0, 0);
        send_cells(16'b0, 1);

        random_start = cells_sent;
        phase = 0;
        while (cells_sent - random_start < CELL_TARGET)
        begin
            phase++;
            steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 39);
            grids = 1;
            pct = 0;
            if (phase == 1)
            begin
                rows = 511;
                cols = 0;
            end
            else if (phase == 2)
            begin
                // Full-width row also fills every line store entry.
                rows = 0;
                cols = 256;
            end
            else if (phase == 3)
            begin
                // Open grid large enough that the counts wrap the modulus.
                rows = 18;
                cols = 22;
            end
            else if (pick < 2)
            begin
                rows = $urandom_range(12, 20);
                cols = $urandom_range(12, 20);
                pct = pick * 3;
            end
            else if (pick == 2)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    rows = $urandom_range(256, 511);
                    cols = $urandom_range(0, 1);
                end
                else
                begin
                    rows = $urandom_range(0, 1);
                    cols = $urandom_range(256, 511);
                end
                pct = $urandom_range(0, 2);
            end
            else
            begin
                rows = $urandom_range(0, 6);
                cols = $urandom_range(0, 6);
                grids = $urandom_range(1, 3);
                case ($urandom_range(0, 4))
                    0: pct = 0;
                    1: pct = 5;
                    2: pct = 15;
                    3: pct = 35;
                    default: pct = 60;
                endcase
            end
            set_grid(rows, cols);
            repeat (grids) finish_grid(pct);

            // Now and then the grid shape changes with a sweep half done.
            if (pick >= 3 && cols_written >= 2 && $urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 20)) send_cell($urandom_range(0, 99) < pct);
                set_grid($urandom_range(0, 8),
                         $urandom_range(1, (cols_written < 8) ? cols_written : 8));
                if (!sweep_at_origin)
                    finish_grid(pct);
            end
        end

        steady = 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
